// ----- design/assert_macros.svh -----
// Assertion macros shared by the pixel conversion RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |-> (rhs)) \
        else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |=> (rhs)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs)
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs)
`endif
`endif

// ----- design/pix2argb_pkg.sv -----
// Types, constants and helper functions for the pixel to ARGB32 converter.
`default_nettype none
package pix2argb_pkg;

    localparam int CompW = 8;
    localparam int SumW  = 27;

    typedef enum logic [1:0] {
        MODE_GRAY  = 2'd0,
        MODE_RGB   = 2'd1,
        MODE_YCBCR = 2'd2,
        MODE_CMYK  = 2'd3
    } t_color_mode;

    localparam t_color_mode ModeReset = MODE_YCBCR;

    // JFIF coefficients rounded to Q16.
    localparam logic signed [17:0] CoefCrToR = 18'sd91881;
    localparam logic signed [17:0] CoefCbToG = 18'sd22554;
    localparam logic signed [17:0] CoefCrToG = 18'sd46802;
    localparam logic signed [17:0] CoefCbToB = 18'sd116130;

    localparam logic [CompW-1:0] ChromaBias = 8'd128;
    localparam logic [CompW-1:0] Opaque     = 8'hff;
    localparam logic [CompW-1:0] ChanMax    = 8'd255;

    // Drop the Q16 fraction and clamp to 0..255.
    function automatic logic [CompW-1:0] sat_q16(input logic signed [SumW-1:0] v);
        logic [CompW-1:0] res;
        if (v[SumW-1]) begin
            res = '0;
        end else if (|v[SumW-2:24]) begin
            res = ChanMax;
        end else begin
            res = v[23:16];
        end
        return res;
    endfunction

    // Exact floor(p / 255) for a product of two 8-bit values.
    function automatic logic [CompW-1:0] div255(input logic [15:0] p);
        logic [16:0] p1;
        logic [16:0] s;
        p1 = {1'b0, p} + 17'd1;
        s  = p1 + {8'd0, p1[16:8]};
        return s[15:8];
    endfunction

endpackage
`default_nettype wire

// ----- design/jpeg_pixel_to_argb.sv -----
// Top level: four-stage pipeline converting a JPEG pixel into an ARGB32 pixel.
`default_nettype none
`include "assert_macros.svh"
// Converts one decoded JPEG pixel (comp0..comp3) into an ARGB32 pixel each clock
// unless the output stalls. The color space (gray, RGB, YCbCr, CMYK) comes from the
// two-bit mode register, which must be written over the cfg channel only while no
// pixel is in flight; the block itself does not enforce this. Reset selects YCbCr.
// A pixel passes the input register with chroma bias removal, the multiplier stage,
// the adder stage, then channel select, saturation or divide-by-255 into the output
// register. One pixel per clock is sustained; each stage moves as soon as the stage
// after it is empty or moving, so an output stall backs up the pipeline without
// losing or repeating pixels. Alpha is always 255.
module jpeg_pixel_to_argb (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_data,      // color_mode
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,    // comp0, comp1, comp2, comp3 (low to high)
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata     // red, green, blue, alpha (low to high)
);
    localparam int W  = pix2argb_pkg::CompW;
    localparam int SW = pix2argb_pkg::SumW;

    pix2argb_pkg::t_color_mode r_mode;

    // Stage valid bits and per-stage advance enables.
    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4 = !r_v4 || m_axis_tready;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    assign s_axis_tready = rdy1;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= pix2argb_pkg::ModeReset;
        end else if (i_cfg_valid) begin
            r_mode <= pix2argb_pkg::t_color_mode'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= s_axis_tvalid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    // Stage 1: capture components, remove chroma bias.
    pix2argb_pkg::t_color_mode r_mode1;
    logic [W-1:0]       r_c0_1, r_c1_1, r_c2_1, r_c3_1;
    logic signed [8:0]  r_cb1, r_cr1;

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_mode1 <= r_mode;
            r_c0_1  <= s_axis_tdata[7:0];
            r_c1_1  <= s_axis_tdata[15:8];
            r_c2_1  <= s_axis_tdata[23:16];
            r_c3_1  <= s_axis_tdata[31:24];
            r_cb1   <= $signed({1'b0, s_axis_tdata[15:8]})
                       - $signed({1'b0, pix2argb_pkg::ChromaBias});
            r_cr1   <= $signed({1'b0, s_axis_tdata[23:16]})
                       - $signed({1'b0, pix2argb_pkg::ChromaBias});
        end
    end

    // Stage 2: coefficient products and CMYK products.
    pix2argb_pkg::t_color_mode r_mode2;
    logic [W-1:0]         r_c0_2, r_c1_2, r_c2_2;
    logic signed [SW-1:0] r_p_r, r_p_gb, r_p_gr, r_p_b;
    logic [15:0]          r_k0, r_k1, r_k2;

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_mode2 <= r_mode1;
            r_c0_2  <= r_c0_1;
            r_c1_2  <= r_c1_1;
            r_c2_2  <= r_c2_1;
            r_p_r   <= SW'(pix2argb_pkg::CoefCrToR) * SW'(r_cr1);
            r_p_gb  <= SW'(pix2argb_pkg::CoefCbToG) * SW'(r_cb1);
            r_p_gr  <= SW'(pix2argb_pkg::CoefCrToG) * SW'(r_cr1);
            r_p_b   <= SW'(pix2argb_pkg::CoefCbToB) * SW'(r_cb1);
            r_k0    <= 16'(r_c0_1) * 16'(r_c3_1);
            r_k1    <= 16'(r_c1_1) * 16'(r_c3_1);
            r_k2    <= 16'(r_c2_1) * 16'(r_c3_1);
        end
    end

    // Stage 3: add luma in Q16 to the chroma terms.
    logic signed [SW-1:0] w_y2;
    assign w_y2 = $signed({3'd0, r_c0_2, 16'd0});

    pix2argb_pkg::t_color_mode r_mode3;
    logic [W-1:0]         r_c0_3, r_c1_3, r_c2_3;
    logic signed [SW-1:0] r_s_r, r_s_g, r_s_b;
    logic [15:0]          r_k0_3, r_k1_3, r_k2_3;

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_mode3 <= r_mode2;
            r_c0_3  <= r_c0_2;
            r_c1_3  <= r_c1_2;
            r_c2_3  <= r_c2_2;
            r_s_r   <= w_y2 + r_p_r;
            r_s_g   <= w_y2 - r_p_gb - r_p_gr;
            r_s_b   <= w_y2 + r_p_b;
            r_k0_3  <= r_k0;
            r_k1_3  <= r_k1;
            r_k2_3  <= r_k2;
        end
    end

    // Stage 4: per-mode channel select into the output register.
    logic [W-1:0] n_red, n_green, n_blue;
    logic [W-1:0] r_red, r_green, r_blue;

    always_comb begin
        unique case (r_mode3)
            pix2argb_pkg::MODE_GRAY: begin
                n_red   = r_c0_3;
                n_green = r_c0_3;
                n_blue  = r_c0_3;
            end
            pix2argb_pkg::MODE_RGB: begin
                n_red   = r_c0_3;
                n_green = r_c1_3;
                n_blue  = r_c2_3;
            end
            pix2argb_pkg::MODE_YCBCR: begin
                n_red   = pix2argb_pkg::sat_q16(r_s_r);
                n_green = pix2argb_pkg::sat_q16(r_s_g);
                n_blue  = pix2argb_pkg::sat_q16(r_s_b);
            end
            default: begin
                n_red   = pix2argb_pkg::div255(r_k0_3);
                n_green = pix2argb_pkg::div255(r_k1_3);
                n_blue  = pix2argb_pkg::div255(r_k2_3);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign m_axis_tvalid = r_v4;
    assign m_axis_tdata  = {pix2argb_pkg::Opaque, r_blue, r_green, r_red};

    // An accepted pixel always lands in the first stage.
    `ASSERT_NEXT(a_accept_fills_s1, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, r_v1)
    // A full third stage whose successor moves hands its pixel on to the fourth.
    `ASSERT_NEXT(a_s3_to_s4, i_clk, i_rst_n, r_v3 && rdy4, r_v4)
    // A stalled output keeps the third stage from advancing into the output stage.
    `ASSERT_IMPLIES(a_stall_blocks, i_clk, i_rst_n, r_v4 && !m_axis_tready, !rdy4)
    // Gray pixels leave with equal color channels.
    `ASSERT_IMPLIES(a_gray_equal, i_clk, i_rst_n,
        r_v3 && rdy4 && r_mode3 == pix2argb_pkg::MODE_GRAY,
        n_red == n_green && n_green == n_blue)

endmodule
`default_nettype wire

// ----- tb/jpeg_pixel_to_argb_tb.sv -----
// Self-checking testbench for the JPEG pixel to ARGB32 converter in all four color modes.
`default_nettype none
module jpeg_pixel_to_argb_tb;

    // Q16 JFIF coefficients, rounded to the nearest integer.
    localparam longint QCrToR = 91881;
    localparam longint QCbToG = 22554;
    localparam longint QCrToG = 46802;
    localparam longint QCbToB = 116130;
    localparam int StallLimit = 2000;
    localparam int HoldCycles = 80;
    localparam int DrainCycles = 12;
    localparam int RandomPerPhase = 150;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_data = 2'd0;
    logic        s_axis_tvalid = 1'b0;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tready = 1'b0;
    logic        o_cfg_ready;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [31:0] m_axis_tdata;

    logic [31:0]  pixel_q[$];          // comp0..comp3, low byte first
    logic [31:0]  expected_argb_q[$];  // red, green, blue, alpha, low byte first
    pix2argb_pkg::t_color_mode active_mode = pix2argb_pkg::ModeReset;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           hold_left = 0;
    int           pixels_seen = 0;
    int           error_count = 0;
    int           quiet_cycles = 0;

    jpeg_pixel_to_argb uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Drop the 16 fraction bits and clamp into one color channel.
    function automatic logic [7:0] clamp_q16(input longint v);
        longint q;
        if (v < 0) begin
            return 8'd0;
        end
        q = v >>> 16;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    function automatic logic [31:0] convert_pixel(input pix2argb_pkg::t_color_mode mode,
                                                  input logic [31:0] pix);
        logic [7:0] c0, c1, c2, c3;
        logic [7:0] r, g, b;
        longint luma, cb, cr;
        int k;
        c0 = pix[7:0];
        c1 = pix[15:8];
        c2 = pix[23:16];
        c3 = pix[31:24];
        case (mode)
            pix2argb_pkg::MODE_GRAY: begin
                r = c0;
                g = c0;
                b = c0;
            end
            pix2argb_pkg::MODE_RGB: begin
                r = c0;
                g = c1;
                b = c2;
            end
            pix2argb_pkg::MODE_YCBCR: begin
                luma = longint'(c0) * 65536;
                cb = longint'(c1) - 128;
                cr = longint'(c2) - 128;
                r = clamp_q16(luma + QCrToR * cr);
                g = clamp_q16(luma - QCbToG * cb - QCrToG * cr);
                b = clamp_q16(luma + QCbToB * cb);
            end
            default: begin
                k = int'(c3);
                r = 8'((int'(c0) * k) / 255);
                g = 8'((int'(c1) * k) / 255);
                b = 8'((int'(c2) * k) / 255);
            end
        endcase
        return {8'hff, b, g, r};
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch at pixel %0d: %s got %0d, expected %0d",
                 pixels_seen, what, got, want);
        error_count++;
    endtask

    // Source side: a transaction completes when tvalid and tready are both high.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_argb_q.push_back(convert_pixel(active_mode, s_axis_tdata));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pixel_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_axis_tdata <= pixel_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Sink side: checks each output transaction and applies back-pressure.
    always @(posedge i_clk) begin
        logic [31:0] want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_argb_q.size() == 0) begin
                    $display("unexpected output pixel %08h", m_axis_tdata);
                    error_count++;
                end else begin
                    want = expected_argb_q.pop_front();
                    if (m_axis_tdata[7:0] !== want[7:0])
                        report_mismatch("red", m_axis_tdata[7:0], want[7:0]);
                    if (m_axis_tdata[15:8] !== want[15:8])
                        report_mismatch("green", m_axis_tdata[15:8], want[15:8]);
                    if (m_axis_tdata[23:16] !== want[23:16])
                        report_mismatch("blue", m_axis_tdata[23:16], want[23:16]);
                    if (m_axis_tdata[31:24] !== want[31:24])
                        report_mismatch("alpha", m_axis_tdata[31:24], want[31:24]);
                end
                pixels_seen++;
                // Long hold-offs let the pipeline fill and stall the source.
                if (pixels_seen == 320 || pixels_seen == 700) begin
                    hold_left = HoldCycles;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= StallLimit) begin
            $display("jpeg_pixel_to_argb test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Checked on the falling edge so that the transfers of the last rising edge have settled.
    task automatic wait_until_drained();
        @(negedge i_clk);
        while (pixel_q.size() > 0 || s_axis_tvalid || expected_argb_q.size() > 0) begin
            @(negedge i_clk);
        end
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_mode(input pix2argb_pkg::t_color_mode mode);
        wait_until_drained();
        i_cfg_data <= mode;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        active_mode = mode;
        i_cfg_valid <= 1'b0;
    endtask

    // Queues the corner pixels (when asked) and then a batch of random ones.
    task automatic queue_pixels(input bit with_corners, input int send_pct,
                                input int recv_pct);
        logic [31:0] corners[6];
        corners[0] = 32'h0000_0000;
        corners[1] = 32'hffff_ffff;
        corners[2] = 32'h0000_ffff;  // full luma, high Cb, low Cr
        corners[3] = 32'hffff_0000;  // zero luma, low Cb, high Cr
        corners[4] = 32'h8080_8080;  // neutral chroma
        corners[5] = 32'h017f_fe01;  // smallest nonzero K
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        if (with_corners) begin
            foreach (corners[i]) pixel_q.push_back(corners[i]);
        end
        repeat (RandomPerPhase) pixel_q.push_back($urandom);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // YCbCr straight out of reset, before any configuration write.
        queue_pixels(1'b1, 23, 23);
        write_mode(pix2argb_pkg::MODE_GRAY);
        queue_pixels(1'b1, 23, 23);
        write_mode(pix2argb_pkg::MODE_RGB);
        queue_pixels(1'b1, 23, 23);
        write_mode(pix2argb_pkg::MODE_CMYK);
        queue_pixels(1'b1, 23, 23);
        write_mode(pix2argb_pkg::MODE_YCBCR);
        queue_pixels(1'b0, 0, 0);
        write_mode(pix2argb_pkg::MODE_CMYK);
        queue_pixels(1'b0, 23, 23);
        wait_until_drained();
        if (expected_argb_q.size() != 0) begin
            $display("%0d expected pixels never arrived", expected_argb_q.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("jpeg_pixel_to_argb test passed");
        end else begin
            $display("jpeg_pixel_to_argb test failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
